// ===== hdl/lte_pkg.sv =====
// Shared types, constants and helpers of the link throughput estimator.
`timescale 1ns / 1ps

package lte_pkg;

  localparam int DEF_RING_DEPTH   = 32;
  localparam int DEF_MIN_RELIABLE = 5;

  localparam logic [5:0]  SAMPLE_CAP_RESET = 6'd20;
  localparam logic [31:0] WINDOW_RESET     = 32'd30000000;

  localparam logic [16:0] Q16_ONE      = 17'd65536;
  localparam logic [16:0] WEIGHT_FLOOR = 17'd6554;

  localparam logic [31:0] SLOW_LIMIT   = 32'd3 << 16;
  localparam logic [31:0] NORMAL_LIMIT = 32'd30 << 16;
  localparam logic [31:0] FAST_LIMIT   = 32'd200 << 16;

  localparam logic [1:0] ACT_RECORD   = 2'd0;
  localparam logic [1:0] ACT_SNAPSHOT = 2'd1;
  localparam logic [1:0] ACT_STATS    = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_TOO_FEW  = 2'd2;

  localparam logic [2:0] CLS_UNKNOWN = 3'd0;
  localparam logic [2:0] CLS_SLOW    = 3'd1;
  localparam logic [2:0] CLS_NORMAL  = 3'd2;
  localparam logic [2:0] CLS_FAST    = 3'd3;
  localparam logic [2:0] CLS_ULTRA   = 3'd4;

  localparam logic REG_SAMPLE_CAP = 1'b0;
  localparam logic REG_WINDOW     = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [39:0] byte_count;
    logic [31:0] duration_us;
    logic [47:0] time_us;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  rate_class;
    logic        reliable;
    logic [5:0]  hit_count;
    logic [31:0] weighted_speed;
    logic [31:0] speed_min;
    logic [31:0] speed_max;
    logic [31:0] mean_speed;
    logic [31:0] stddev_speed;
  } rsp_t;

  function automatic logic [2:0] classify(input logic [31:0] s);
    logic [2:0] c;
    if (s < SLOW_LIMIT) c = CLS_SLOW;
    else if (s < NORMAL_LIMIT) c = CLS_NORMAL;
    else if (s < FAST_LIMIT) c = CLS_FAST;
    else c = CLS_ULTRA;
    return c;
  endfunction

endpackage

// ===== hdl/lte_ring.sv =====
// Sample ring memory: one write port, one registered read port.
`timescale 1ns / 1ps

module lte_ring
  import lte_pkg::*;
#(
  parameter int RING_DEPTH = DEF_RING_DEPTH,
  parameter int AW = $clog2(RING_DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wspeed,
  input  logic [47:0]   wtime,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rspeed,
  output logic [47:0]   rtime
);

  logic [31:0] speed_mem [RING_DEPTH];
  logic [47:0] time_mem  [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      speed_mem[waddr] <= wspeed;
      time_mem[waddr]  <= wtime;
    end
    rspeed <= speed_mem[raddr];
    rtime  <= time_mem[raddr];
  end

endmodule

// ===== hdl/lte_div.sv =====
// Restoring divider, one quotient bit per cycle, for a chosen number of quotient bits.
`timescale 1ns / 1ps

module lte_div
  import lte_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  input  logic [6:0]  nbits,
  output logic        done,
  output logic [63:0] quotient
);

  // The caller guarantees the quotient fits in nbits bits, so the
  // remainder starts as the dividend bits above them.
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [6:0]  cnt;
  logic        running;
  logic [32:0] trial;
  logic        ge;

  assign trial = {rem, quotient[63]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt     <= nbits;
        dvs     <= divisor;
      end else if (running) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem      <= 32'(dividend >> nbits);
      quotient <= dividend << (7'd64 - nbits);
    end else if (running) begin
      rem      <= ge ? 32'(trial - {1'b0, dvs}) : trial[31:0];
      quotient <= {quotient[62:0], ge};
    end
  end

endmodule

// ===== hdl/lte_sqrt.sv =====
// Integer square root of a 64-bit value, two radicand bits per cycle.
`timescale 1ns / 1ps

module lte_sqrt
  import lte_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] x;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [5:0]  cnt;
  logic        running;
  logic [63:0] trial;

  assign trial = res + bitv;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt     <= 6'd32;
      end else if (running) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      x    <= radicand;
      res  <= '0;
      bitv <= 64'd1 << 62;
    end else if (running) begin
      if (x >= trial) begin
        x   <= x - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

// ===== hdl/link_throughput_estimator.sv =====
// Top level: link throughput estimator with sample ring and query sequencer.
`timescale 1ns / 1ps
// A record runs the speed division, then one estimate pass; an estimate pass runs one
// 17-bit weight division per counted entry and, when enough entries count, a final
// division; statistics run two passes with a mean division, a variance division and a square root.
// The result strobe is registered and rises in the cycle after the last state.
// One request is worked at a time (busy high), as the divider and the ring read port are shared.
// Each result shows for one cycle with done; the receiver cannot stall it. Reset clears state.

module link_throughput_estimator
  import lte_pkg::*;
#(
  parameter int RING_DEPTH   = DEF_RING_DEPTH,
  parameter int MIN_RELIABLE = DEF_MIN_RELIABLE
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        request,
  output logic        done,
  output rsp_t        result,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int FW = $clog2(RING_DEPTH + 1);

  // Sequencer states. A pass walks the filled entries oldest first: read,
  // check, then optional weight division or accumulate.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SPD   = 4'd1;
  localparam logic [3:0] S_PINIT = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd4;
  localparam logic [3:0] S_WDIV  = 4'd5;
  localparam logic [3:0] S_WACC  = 4'd6;
  localparam logic [3:0] S_VACC  = 4'd7;
  localparam logic [3:0] S_NEXT  = 4'd8;
  localparam logic [3:0] S_PEND  = 4'd9;
  localparam logic [3:0] S_FDIV  = 4'd10;
  localparam logic [3:0] S_MDIV  = 4'd11;
  localparam logic [3:0] S_VDIV  = 4'd12;
  localparam logic [3:0] S_SQRT  = 4'd13;

  // Pass kinds.
  localparam logic [1:0] P_EST = 2'd0;
  localparam logic [1:0] P_ST1 = 2'd1;
  localparam logic [1:0] P_ST2 = 2'd2;

  // Response of a rejected request: invalid status, every other field zero.
  function automatic rsp_t invalid_rsp();
    rsp_t r;
    r        = '0;
    r.status = ST_INVALID;
    return r;
  endfunction

  logic [3:0]  state;
  logic [1:0]  pass;
  logic [5:0]  sample_cap;
  logic [31:0] window_us;

  logic [47:0] now_r;
  logic [31:0] win_r;
  logic [AW-1:0] wp;
  logic [FW-1:0] fill;
  logic [AW-1:0] idx;
  logic [FW-1:0] icnt;
  logic [FW-1:0] n;
  logic [63:0] wsum;
  logic [31:0] wtot;
  logic [47:0] sum;
  logic [31:0] mn;
  logic [31:0] mx;
  logic [31:0] mean;
  logic [63:0] var_acc;
  logic [31:0] dreg;
  logic [16:0] wreg;

  // Ring.
  logic          ring_we;
  logic [31:0]   ring_wspeed;
  logic [31:0]   rd_speed;
  logic [47:0]   rd_time;

  // Shared divider and square root unit.
  logic        div_go;
  logic [63:0] div_dividend;
  logic [31:0] div_divisor;
  logic [6:0]  div_nbits;
  logic        div_done;
  logic [63:0] div_q;
  logic        sq_go;
  logic [63:0] sq_radicand;
  logic        sq_done;
  logic [31:0] sq_root;

  lte_ring #(.RING_DEPTH(RING_DEPTH), .AW(AW)) u_ring (
    .clk    (clk),
    .we     (ring_we),
    .waddr  (wp),
    .wspeed (ring_wspeed),
    .wtime  (now_r),
    .raddr  (idx),
    .rspeed (rd_speed),
    .rtime  (rd_time)
  );

  lte_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .nbits    (div_nbits),
    .done     (div_done),
    .quotient (div_q)
  );

  lte_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .go       (sq_go),
    .radicand (sq_radicand),
    .done     (sq_done),
    .root     (sq_root)
  );

  assign busy = (state != S_IDLE);

  // The measured speed saturates to 32 bits; the ring is written once the
  // speed division finishes.
  assign ring_wspeed = (div_q[63:32] != 32'd0) ? 32'hFFFF_FFFF : div_q[31:0];
  assign ring_we     = (state == S_SPD) && div_done;

  // Effective sample cap: zero means the default, and never beyond the ring.
  logic [5:0]    ms_eff;
  logic [FW-1:0] cap;
  logic [FW:0]   fill_inc;
  assign ms_eff   = (sample_cap == 6'd0) ? SAMPLE_CAP_RESET : sample_cap;
  assign cap      = (int'(ms_eff) > RING_DEPTH) ? FW'(RING_DEPTH) : FW'(ms_eff);
  assign fill_inc = {1'b0, fill} + (FW+1)'(1);

  // Oldest entry: the write pointer moved back by the fill count, modulo the depth.
  logic [AW:0] start_t;
  logic [AW-1:0] start_idx;
  assign start_t   = {1'b0, wp} + (AW+1)'(RING_DEPTH) - (AW+1)'(fill);
  assign start_idx = (int'(start_t) >= RING_DEPTH) ? AW'(int'(start_t) - RING_DEPTH)
                                                   : start_t[AW-1:0];

  // Age check of the entry just read. Samples not older than now have age zero.
  logic [47:0] age;
  logic        counted;
  assign age     = (now_r > rd_time) ? (now_r - rd_time) : 48'd0;
  assign counted = (age <= {16'd0, win_r}) && (rd_speed != 32'd0);

  // Weight from the age division, raised to the floor of one tenth.
  logic [16:0] wraw;
  assign wraw = Q16_ONE - div_q[16:0];

  // Full-width products for the weighted sum and the squared deviation.
  logic [48:0] wprod;
  logic [63:0] dsq;
  assign wprod = {17'd0, rd_speed} * {32'd0, wreg};
  assign dsq   = {32'd0, dreg} * {32'd0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_cap <= SAMPLE_CAP_RESET;
      window_us  <= WINDOW_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_SAMPLE_CAP) sample_cap <= cfg_data[5:0];
      else window_us <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      wp     <= '0;
      fill   <= '0;
      done   <= 1'b0;
      div_go <= 1'b0;
      sq_go  <= 1'b0;
    end else begin
      done   <= 1'b0;
      div_go <= 1'b0;
      sq_go  <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            now_r  <= request.time_us;
            win_r  <= (window_us == 32'd0) ? WINDOW_RESET : window_us;
            case (request.action)
              ACT_RECORD: begin
                if (request.byte_count == 40'd0 || request.duration_us == 32'd0) begin
                  result <= invalid_rsp();
                  done   <= 1'b1;
                end else begin
                  result       <= '0;
                  div_go       <= 1'b1;
                  div_dividend <= {5'd0, request.byte_count, 19'd0};
                  div_divisor  <= request.duration_us;
                  div_nbits    <= 7'd59;
                  state        <= S_SPD;
                end
              end
              ACT_SNAPSHOT: begin
                result <= '0;
                pass   <= P_EST;
                state  <= S_PINIT;
              end
              ACT_STATS: begin
                result <= '0;
                pass   <= P_ST1;
                state  <= S_PINIT;
              end
              default: begin
                result <= invalid_rsp();
                done   <= 1'b1;
              end
            endcase
          end
        end

        S_SPD: begin
          if (div_done) begin
            wp    <= (int'(wp) == RING_DEPTH - 1) ? '0 : wp + AW'(1);
            fill  <= (fill_inc < {1'b0, cap}) ? fill_inc[FW-1:0] : cap;
            pass  <= P_EST;
            state <= S_PINIT;
          end
        end

        S_PINIT: begin
          idx  <= start_idx;
          icnt <= '0;
          if (pass == P_ST2) begin
            var_acc <= '0;
          end else begin
            n    <= '0;
            wsum <= '0;
            wtot <= '0;
            sum  <= '0;
          end
          state <= (fill == '0) ? S_PEND : S_RD;
        end

        S_RD: begin
          state <= S_CHK;
        end

        S_CHK: begin
          if (!counted) begin
            state <= S_NEXT;
          end else begin
            case (pass)
              P_EST: begin
                div_go       <= 1'b1;
                div_dividend <= {age, 16'd0};
                div_divisor  <= win_r;
                div_nbits    <= 7'd17;
                state        <= S_WDIV;
              end
              P_ST1: begin
                if (n == '0 || rd_speed < mn) mn <= rd_speed;
                if (n == '0 || rd_speed > mx) mx <= rd_speed;
                sum   <= sum + {16'd0, rd_speed};
                n     <= n + FW'(1);
                state <= S_NEXT;
              end
              default: begin
                dreg  <= (rd_speed > mean) ? rd_speed - mean : mean - rd_speed;
                state <= S_VACC;
              end
            endcase
          end
        end

        S_WDIV: begin
          if (div_done) begin
            wreg  <= (wraw < WEIGHT_FLOOR) ? WEIGHT_FLOOR : wraw;
            state <= S_WACC;
          end
        end

        S_WACC: begin
          wsum  <= wsum + {15'd0, wprod};
          wtot  <= wtot + {15'd0, wreg};
          n     <= n + FW'(1);
          state <= S_NEXT;
        end

        S_VACC: begin
          var_acc <= var_acc + {16'd0, dsq[63:16]};
          state   <= S_NEXT;
        end

        S_NEXT: begin
          if ({1'b0, icnt} + (FW+1)'(1) == {1'b0, fill}) begin
            state <= S_PEND;
          end else begin
            icnt  <= icnt + FW'(1);
            idx   <= (int'(idx) == RING_DEPTH - 1) ? '0 : idx + AW'(1);
            state <= S_RD;
          end
        end

        S_PEND: begin
          result.hit_count <= 6'(n);
          case (pass)
            P_EST: begin
              if (int'(n) >= MIN_RELIABLE && wtot != 32'd0) begin
                div_go       <= 1'b1;
                div_dividend <= wsum;
                div_divisor  <= wtot;
                div_nbits    <= 7'd32;
                state        <= S_FDIV;
              end else begin
                done  <= 1'b1;
                state <= S_IDLE;
              end
            end
            P_ST1: begin
              if (int'(n) < 2) begin
                result.status <= ST_TOO_FEW;
                done          <= 1'b1;
                state         <= S_IDLE;
              end else begin
                div_go       <= 1'b1;
                div_dividend <= {16'd0, sum};
                div_divisor  <= 32'(n);
                div_nbits    <= 7'd48;
                state        <= S_MDIV;
              end
            end
            default: begin
              div_go       <= 1'b1;
              div_dividend <= var_acc;
              div_divisor  <= 32'(n);
              div_nbits    <= 7'd64;
              state        <= S_VDIV;
            end
          endcase
        end

        S_FDIV: begin
          if (div_done) begin
            result.weighted_speed <= div_q[31:0];
            result.rate_class     <= classify(div_q[31:0]);
            result.reliable       <= 1'b1;
            done                  <= 1'b1;
            state                 <= S_IDLE;
          end
        end

        S_MDIV: begin
          if (div_done) begin
            mean  <= div_q[31:0];
            pass  <= P_ST2;
            state <= S_PINIT;
          end
        end

        S_VDIV: begin
          if (div_done) begin
            sq_go       <= 1'b1;
            sq_radicand <= {div_q[47:0], 16'd0};
            state       <= S_SQRT;
          end
        end

        S_SQRT: begin
          if (sq_done) begin
            result.speed_min    <= mn;
            result.speed_max    <= mx;
            result.mean_speed   <= mean;
            result.stddev_speed <= sq_root;
            done                <= 1'b1;
            state               <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
